// File: src/tppt_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoid point timer package
// Phase codes and configuration register indexes shared by the block.
// ----------------------------------------------------------------------------
package tppt_pkg;

  typedef logic [1:0] phase_t;

  localparam phase_t PHASE_ACCEL  = 2'd0;
  localparam phase_t PHASE_CRUISE = 2'd1;
  localparam phase_t PHASE_DECEL  = 2'd2;
  localparam phase_t PHASE_ERROR  = 2'd3;

  typedef logic reg_index_t;

  localparam reg_index_t REG_TOTAL_LENGTH = 1'b0;
  localparam reg_index_t REG_CRUISE_SPEED = 1'b1;

endpackage

// File: src/trapezoid_profile_point_timer_unit.sv
// ----------------------------------------------------------------------------
// Trapezoid profile point timer
// Gives the arrival time of each path point along a trapezoidal velocity
// profile, using a bit-serial multiplier, square root and divider.
// ----------------------------------------------------------------------------
// Usage:
//   Write total_length (index 0) and cruise_speed (index 1) through cfg_we,
//   cfg_index and cfg_data while the block is idle. Each input transaction
//   carries one segment length; first_in_group restarts the running
//   distance. Each input gives exactly one output transaction with the
//   arrival time and the profile phase.
//   From the accepting edge to out_valid: beyond-length or zero speed goes
//   from classification straight to the output stage; cruise runs the
//   divider alone; accelerate and decelerate run the multiplier, the square
//   root and the divider in turn. in_ready returns in the cycle after the
//   result is loaded. The multiplier is shift-add, the square root is
//   restoring (two radicand bits per cycle) and so is the divider (one
//   quotient bit per cycle). One item is worked on at a time; a new one is
//   taken once the previous result sits in the output register.
//   Reset clears the state, the configuration registers, the running
//   distance and out_valid. When the receiver stalls, the finished result
//   waits in the output register and the next item is still taken and
//   computed; its result then holds until the output register frees.
// ----------------------------------------------------------------------------
module trapezoid_profile_point_timer_unit #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [VALUE_WIDTH-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] segment_length,
  input  logic                   first_in_group,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] arrival_time,
  output logic [1:0]             phase
);

  localparam int W    = VALUE_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW   = W + 1;
  localparam int AW   = W + 7;
  localparam int PRW  = 2 * W + 7;
  localparam int RW   = PRW + 2 * F + 1;
  localparam int SW   = RW / 2;
  localparam int NW   = SW;
  localparam int DENW = W + 4;
  localparam int CW   = $clog2(SW + 1);

  localparam logic [CW-1:0] MUL_LAST = CW'(W - 1);
  localparam logic [CW-1:0] SQ_LAST  = CW'(SW - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(NW - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLASS = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_SQRT  = 3'd3;
  localparam logic [2:0] ST_PREP  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]            state;
  logic [CW-1:0]         cnt;
  logic [DW-1:0]         run_dist;
  logic [W-1:0]          s_reg;
  logic [W-1:0]          v_reg;
  tppt_pkg::phase_t      phase_r;
  logic [AW-1:0]         ma;
  logic [W-1:0]          mb;
  logic [PRW-1:0]        prod;
  logic [RW-1:0]         rad;
  logic [SW-1:0]         root;
  logic [SW+1:0]         srem;
  logic [NW-1:0]         num;
  logic [DENW-1:0]       den;
  logic [DENW-1:0]       drem;
  logic [NW-1:0]         quo;
  logic [W-1:0]          res_time;

  // Running distance update.
  logic [W+1:0]          dist_sum;
  logic [DW-1:0]         dist_next;

  // Classification terms.
  logic [DW+3:0]         d10;
  logic [DW+3:0]         s_ext;
  logic [DW+3:0]         s9;
  logic [DW+3:0]         cr_sum;
  logic [DENW-1:0]       v10;
  logic [DENW-1:0]       v5;
  logic                  is_err;
  logic                  is_accel;
  logic                  is_cruise;

  // Serial step terms.
  logic [PRW-1:0]        prod_next;
  logic [SW+1:0]         rem2;
  logic [SW+1:0]         trial;
  logic [SW:0]           c_up;
  logic [NW-1:0]         six_s;
  logic [DENW:0]         r2;
  logic                  out_load;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    dist_sum  = {1'b0, run_dist} + {2'b0, segment_length};
    if (first_in_group) begin
      dist_next = {1'b0, segment_length};
    end else if (dist_sum[W+1]) begin
      dist_next = {DW{1'b1}};
    end else begin
      dist_next = dist_sum[DW-1:0];
    end

    d10       = {1'b0, run_dist, 3'b000} + {3'b000, run_dist, 1'b0};
    s_ext     = {{(DW+4-W){1'b0}}, s_reg};
    s9        = {s_ext[DW:0], 3'b000} + s_ext;
    cr_sum    = d10 + s_ext;
    v10       = {1'b0, v_reg, 3'b000} + {3'b000, v_reg, 1'b0};
    v5        = {2'b00, v_reg, 2'b00} + {4'b0000, v_reg};
    is_err    = (v_reg == '0) || (run_dist > {1'b0, s_reg});
    is_accel  = d10 < s_ext;
    is_cruise = d10 < s9;

    prod_next = {prod[PRW-2:0], 1'b0} + (mb[W-1] ? {{(PRW-AW){1'b0}}, ma} : {PRW{1'b0}});

    rem2      = {srem[SW-1:0], rad[RW-1:RW-2]};
    trial     = {root, 2'b01};

    // Ceiling of the root: round up when the remainder is not zero.
    c_up      = {1'b0, root} + {{SW{1'b0}}, (srem != '0)};
    six_s     = NW'({({2'b00, s_reg, 1'b0} + {1'b0, s_reg, 2'b00}), {F{1'b0}}});

    r2        = {drem, num[NW-1]};
    out_load  = (state == ST_FIN) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      run_dist  <= '0;
      s_reg     <= '0;
      v_reg     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tppt_pkg::REG_TOTAL_LENGTH: s_reg <= cfg_data;
          tppt_pkg::REG_CRUISE_SPEED: v_reg <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            run_dist <= dist_next;
            state    <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          cnt  <= '0;
          prod <= '0;
          if (is_err) begin
            phase_r  <= tppt_pkg::PHASE_ERROR;
            res_time <= '0;
            state    <= ST_FIN;
          end else if (is_accel) begin
            phase_r <= tppt_pkg::PHASE_ACCEL;
            ma      <= {d10[AW-3:0], 2'b00};
            mb      <= s_reg;
            den     <= v10;
            state   <= ST_MUL;
          end else if (is_cruise) begin
            phase_r <= tppt_pkg::PHASE_CRUISE;
            num     <= {cr_sum[DENW-1:0], {F{1'b0}}};
            den     <= v10;
            drem    <= '0;
            quo     <= '0;
            state   <= ST_DIV;
          end else begin
            phase_r <= tppt_pkg::PHASE_DECEL;
            ma      <= {4'b0000, s_reg, 3'b000} + {6'b000000, s_reg, 1'b0};
            mb      <= s_reg - run_dist[W-1:0];
            den     <= v5;
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod <= prod_next;
          mb   <= {mb[W-2:0], 1'b0};
          if (cnt == MUL_LAST) begin
            rad   <= {1'b0, prod_next, {(2*F){1'b0}}};
            root  <= '0;
            srem  <= '0;
            cnt   <= '0;
            state <= ST_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SQRT: begin
          rad <= {rad[RW-3:0], 2'b00};
          if (rem2 >= trial) begin
            srem <= rem2 - trial;
            root <= {root[SW-2:0], 1'b1};
          end else begin
            srem <= rem2;
            root <= {root[SW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == SQ_LAST) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (phase_r == tppt_pkg::PHASE_ACCEL) begin
            num <= root;
          end else if ({1'b0, six_s} >= c_up) begin
            num <= six_s - c_up[NW-1:0];
          end else begin
            num <= '0;
          end
          drem  <= '0;
          quo   <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          num <= {num[NW-2:0], 1'b0};
          if (r2 >= {1'b0, den}) begin
            drem <= DENW'(r2 - {1'b0, den});
            quo  <= {quo[NW-2:0], 1'b1};
          end else begin
            drem <= r2[DENW-1:0];
            quo  <= {quo[NW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register; an error gives time zero and the quotient saturates to the largest time.
  always_ff @(posedge clk) begin
    if (out_load) begin
      phase <= phase_r;
      if (phase_r == tppt_pkg::PHASE_ERROR) begin
        arrival_time <= res_time;
      end else if (quo[NW-1:W] != '0) begin
        arrival_time <= {W{1'b1}};
      end else begin
        arrival_time <= quo[W-1:0];
      end
    end
  end

endmodule
